// ===== src/gsm_pkg.sv =====
// Shared types and byte codes for the glob segment matcher.
package gsm_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_NAME   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_ADDR,
    ST_P_DATA,
    ST_ESC,
    ST_CL_NEG,
    ST_CL_A,
    ST_CL_D0,
    ST_CL_D1,
    ST_CL_D2,
    ST_FIN
  } state_t;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_BSL   = 8'h5C;

endpackage

// ===== src/glob_segment_matcher.sv =====
// Glob segment matcher top level: pattern store and position-walking sequencer.
// Load a pattern with a start word and then one append word per byte, stream the
// name one word per byte, and finish with an end-of-name word, which yields one
// result word (matched, pattern_overflow). Start and append words are taken in idle.
// A name or end word walks the stored pattern positions 0..length-1 through one
// registered read port of the pattern memory: each position takes an address and a
// data state, an active escape adds an escape state, and an active class adds a
// negation check and then address and data states per range or member test; a
// word with an empty pattern goes straight to the final state, and in_ready stays
// low until the walk is back in idle. An end word also holds in the final state
// while an earlier result word is still waiting on out_ready.
// The walk is serial, one position at a time, through the single read port.
module glob_segment_matcher #(
  parameter int MAX_PATTERN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       matched,
  output logic       pattern_overflow
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);

  gsm_pkg::state_t state, state_next;

  logic [7:0]         mem [MAX_PATTERN];
  logic [7:0]         rdata;
  logic [AW-1:0]      raddr;
  logic [LW-1:0]      len, len_next;
  logic               ovf, ovf_next;
  logic [MAX_PATTERN:0] active, active_next;
  logic [MAX_PATTERN:0] nact, nact_next;
  logic [LW-1:0]      p, p_next;
  logic [LW-1:0]      j, j_next;
  logic               neg, neg_next;
  logic               hit, hit_next;
  logic               starc, starc_next;
  logic               is_end, is_end_next;
  logic [7:0]         cbyte, cbyte_next;
  logic [7:0]         b0, b0_next;
  logic [7:0]         b1, b1_next;
  logic               out_valid_next, matched_next, povf_next;

  logic [LW:0] p1, p2, j1, j2, j3;
  logic        accept, adv, cur, cur_len;
  logic signed [7:0] ra, rb, rv, rlo, rhi;

  assign accept = in_valid && in_ready;
  assign p1 = {1'b0, p} + (LW+1)'(1);
  assign p2 = {1'b0, p} + (LW+1)'(2);
  assign j1 = {1'b0, j} + (LW+1)'(1);
  assign j2 = {1'b0, j} + (LW+1)'(2);
  assign j3 = {1'b0, j} + (LW+1)'(3);
  assign cur = active[p] | starc;
  assign cur_len = active[len] | starc;
  assign ra = $signed(b0);
  assign rb = $signed(rdata);
  assign rv = $signed(cbyte);
  assign rlo = (ra > rb) ? rb : ra;
  assign rhi = (ra > rb) ? ra : rb;

  always_ff @(posedge clk) begin
    if (accept && gsm_pkg::cmd_t'(command) == gsm_pkg::CMD_APPEND &&
        len != LW'(MAX_PATTERN)) begin
      mem[len[AW-1:0]] <= byte_value;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    in_ready = (state == gsm_pkg::ST_IDLE);
    unique case (state)
      gsm_pkg::ST_P_DATA: raddr = p1[AW-1:0];
      gsm_pkg::ST_CL_A:   raddr = j[AW-1:0];
      gsm_pkg::ST_CL_D0:  raddr = j1[AW-1:0];
      gsm_pkg::ST_CL_D1:  raddr = j2[AW-1:0];
      default:            raddr = p[AW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    len_next = len;
    ovf_next = ovf;
    active_next = active;
    nact_next = nact;
    p_next = p;
    j_next = j;
    neg_next = neg;
    hit_next = hit;
    starc_next = starc;
    is_end_next = is_end;
    cbyte_next = cbyte;
    b0_next = b0;
    b1_next = b1;
    out_valid_next = out_valid && !out_ready;
    matched_next = matched;
    povf_next = pattern_overflow;
    adv = 1'b0;
    unique case (state)
      gsm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (gsm_pkg::cmd_t'(command))
            gsm_pkg::CMD_START: begin
              len_next = '0;
              ovf_next = 1'b0;
              active_next = (MAX_PATTERN+1)'(1);
            end
            gsm_pkg::CMD_APPEND: begin
              if (len != LW'(MAX_PATTERN)) len_next = len + LW'(1);
              else ovf_next = 1'b1;
              active_next = (MAX_PATTERN+1)'(1);
            end
            default: begin
              p_next = '0;
              starc_next = 1'b0;
              nact_next = '0;
              cbyte_next = byte_value;
              is_end_next = (gsm_pkg::cmd_t'(command) == gsm_pkg::CMD_END);
              state_next = (len == '0) ? gsm_pkg::ST_FIN : gsm_pkg::ST_P_ADDR;
            end
          endcase
        end
      end
      gsm_pkg::ST_P_ADDR: state_next = gsm_pkg::ST_P_DATA;
      gsm_pkg::ST_P_DATA: begin
        starc_next = cur && rdata == gsm_pkg::CH_STAR;
        if (!cur || is_end) begin
          adv = 1'b1;
        end else begin
          priority case (rdata)
            gsm_pkg::CH_STAR: begin
              nact_next[p] = 1'b1;
              adv = 1'b1;
            end
            gsm_pkg::CH_QMARK: begin
              nact_next[p1[LW-1:0]] = 1'b1;
              adv = 1'b1;
            end
            gsm_pkg::CH_BSL: state_next = gsm_pkg::ST_ESC;
            gsm_pkg::CH_LBR: state_next = gsm_pkg::ST_CL_NEG;
            default: begin
              if (rdata == cbyte) nact_next[p1[LW-1:0]] = 1'b1;
              adv = 1'b1;
            end
          endcase
        end
      end
      gsm_pkg::ST_ESC: begin
        if (p1 < {1'b0, len} && rdata == cbyte) nact_next[p2[LW-1:0]] = 1'b1;
        adv = 1'b1;
      end
      gsm_pkg::ST_CL_NEG: begin
        hit_next = 1'b0;
        if (p1 < {1'b0, len} && (rdata == gsm_pkg::CH_BANG || rdata == gsm_pkg::CH_CARET)) begin
          neg_next = 1'b1;
          j_next = p2[LW-1:0];
        end else begin
          neg_next = 1'b0;
          j_next = p1[LW-1:0];
        end
        state_next = gsm_pkg::ST_CL_A;
      end
      gsm_pkg::ST_CL_A: begin
        if (j >= len) adv = 1'b1;
        else state_next = gsm_pkg::ST_CL_D0;
      end
      gsm_pkg::ST_CL_D0: begin
        b0_next = rdata;
        if (rdata == gsm_pkg::CH_RBR) begin
          if (hit != neg) nact_next[j1[LW-1:0]] = 1'b1;
          adv = 1'b1;
        end else if (j2 < {1'b0, len}) begin
          state_next = gsm_pkg::ST_CL_D1;
        end else begin
          if (rdata == cbyte) hit_next = 1'b1;
          j_next = j1[LW-1:0];
          state_next = gsm_pkg::ST_CL_A;
        end
      end
      gsm_pkg::ST_CL_D1: begin
        b1_next = rdata;
        state_next = gsm_pkg::ST_CL_D2;
      end
      gsm_pkg::ST_CL_D2: begin
        if (b1 == gsm_pkg::CH_DASH && rdata != gsm_pkg::CH_RBR) begin
          if (rv >= rlo && rv <= rhi) hit_next = 1'b1;
          j_next = j3[LW-1:0];
        end else begin
          if (b0 == cbyte) hit_next = 1'b1;
          j_next = j1[LW-1:0];
        end
        state_next = gsm_pkg::ST_CL_A;
      end
      gsm_pkg::ST_FIN: begin
        if (!is_end) begin
          active_next = nact;
          state_next = gsm_pkg::ST_IDLE;
        end else if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          matched_next = cur_len && !ovf;
          povf_next = ovf;
          active_next = (MAX_PATTERN+1)'(1);
          state_next = gsm_pkg::ST_IDLE;
        end
      end
      default: state_next = gsm_pkg::ST_IDLE;
    endcase
    if (adv) begin
      p_next = p1[LW-1:0];
      state_next = (p1 == {1'b0, len}) ? gsm_pkg::ST_FIN : gsm_pkg::ST_P_ADDR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsm_pkg::ST_IDLE;
      len <= '0;
      ovf <= 1'b0;
      active <= (MAX_PATTERN+1)'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len <= len_next;
      ovf <= ovf_next;
      active <= active_next;
      out_valid <= out_valid_next;
    end
    nact <= nact_next;
    p <= p_next;
    j <= j_next;
    neg <= neg_next;
    hit <= hit_next;
    starc <= starc_next;
    is_end <= is_end_next;
    cbyte <= cbyte_next;
    b0 <= b0_next;
    b1 <= b1_next;
    matched <= matched_next;
    pattern_overflow <= povf_next;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(MAX_PATTERN))
    else $error("pattern length beyond store");

  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && pattern_overflow |-> !matched)
    else $error("match reported with overflow");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && gsm_pkg::cmd_t'(command) == gsm_pkg::CMD_START |=> len == '0 && !ovf)
    else $error("start word did not clear pattern");

  a_busy_walk: assert property (@(posedge clk) disable iff (rst)
    state != gsm_pkg::ST_IDLE && state != gsm_pkg::ST_FIN |-> p < len)
    else $error("position walk past pattern end");

endmodule
